@@ hdl/slsdc_pkg.sv @@
package slsdc_pkg;

	localparam int unsigned PART_W = 16;
	localparam int unsigned MAG_W = 15;
	localparam int unsigned POWER_W = 31;
	localparam int unsigned DUTY_W = 16;
	localparam int unsigned TIMER_W = 16;
	localparam int unsigned LANES = 3;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DANCE_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DANCE_HOLD = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_TICKS = 2'd3;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [POWER_W-1:0] SLEEP_THRESHOLD_RST = 31'd1000;
	localparam logic [POWER_W-1:0] DANCE_THRESHOLD_RST = 31'd100000;
	localparam logic [TIMER_W-1:0] DANCE_HOLD_RST = 16'd100;
	localparam logic [TIMER_W-1:0] SLEEP_TICKS_RST = 16'd3750;

	localparam logic [DUTY_W-1:0] DUTY_CLAMP = 16'hB000;
	localparam int unsigned POWER_SHIFT = 2;
	localparam int unsigned QUARTER_SHIFT = 2;

	typedef struct packed {
		logic op;
		logic signed [PART_W-1:0] bin1_real;
		logic signed [PART_W-1:0] bin1_imag;
		logic signed [PART_W-1:0] bin2_real;
		logic signed [PART_W-1:0] bin2_imag;
		logic signed [PART_W-1:0] bin3_real;
		logic signed [PART_W-1:0] bin3_imag;
	} item_word_t;

	typedef struct packed {
		logic asleep;
		logic dancing;
		logic duty_update;
		logic [DUTY_W-1:0] red_duty;
		logic [DUTY_W-1:0] green_duty;
		logic [DUTY_W-1:0] blue_duty;
	} result_word_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_word_t;

	typedef struct packed {
		logic over_sleep;
		logic over_dance;
		logic over_quarter;
		logic [DUTY_W-1:0] duty;
	} lane_report_t;

	typedef struct packed {
		logic valid;
		logic op;
	} stage_ctl_t;

endpackage

@@ hdl/slsdc_ifs.sv @@
interface slsdc_item_if;
	logic valid;
	logic ready;
	slsdc_pkg::item_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slsdc_result_if;
	logic valid;
	logic ready;
	slsdc_pkg::result_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slsdc_cfg_if;
	logic valid;
	logic ready;
	slsdc_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sound_level_sleep_dance_control.sv @@
// sound level sleep and dance control
// channels: item (sink) takes a frame word (op 0, three complex bins) or a
// tick word (op 1); result (source) gives exactly one word per item, in order;
// cfg (sink) writes registers 0..3: sleep_threshold, dance_threshold,
// dance_hold, sleep_ticks; cfg is always ready
// three bin lanes square and sum in parallel, a merge stage updates the
// hold timer, quiet count and sleep state and loads the output register
// path: an accepted item is registered in stage one, then the merge stage
// loads the output register, which raises result.valid
// throughput: one item per cycle; item.ready drops only while the output
// register holds a word and result.ready is low with stage one occupied
// reset: registers go to their default values, the block is awake, the hold
// timer and quiet count are zero and no word is pending
// a stalled receiver holds the result word steady; one more item can sit in
// stage one before item.ready falls
module sound_level_sleep_dance_control (
	input  logic clk,
	input  logic arst_n,
	slsdc_item_if.sink item,
	slsdc_result_if.source result,
	slsdc_cfg_if.sink cfg
);

	logic [slsdc_pkg::POWER_W-1:0] sleep_threshold_q;
	logic [slsdc_pkg::POWER_W-1:0] dance_threshold_q;
	logic [slsdc_pkg::TIMER_W-1:0] dance_hold_q;
	logic [slsdc_pkg::TIMER_W-1:0] sleep_ticks_q;

	logic advance;
	logic accept;
	slsdc_pkg::stage_ctl_t ctl_s1;
	slsdc_pkg::lane_report_t rep [slsdc_pkg::LANES];

	assign cfg.ready = 1'b1;
	assign item.ready = !ctl_s1.valid || advance;
	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_threshold_q <= slsdc_pkg::SLEEP_THRESHOLD_RST;
			dance_threshold_q <= slsdc_pkg::DANCE_THRESHOLD_RST;
			dance_hold_q <= slsdc_pkg::DANCE_HOLD_RST;
			sleep_ticks_q <= slsdc_pkg::SLEEP_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				slsdc_pkg::CFG_SLEEP_THRESHOLD: sleep_threshold_q <= cfg.data.data;
				slsdc_pkg::CFG_DANCE_THRESHOLD: dance_threshold_q <= cfg.data.data;
				slsdc_pkg::CFG_DANCE_HOLD:
					dance_hold_q <= cfg.data.data[slsdc_pkg::TIMER_W-1:0];
				slsdc_pkg::CFG_SLEEP_TICKS:
					sleep_ticks_q <= cfg.data.data[slsdc_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid <= 1'b0;
			ctl_s1.op <= slsdc_pkg::OP_FRAME;
		end else begin
			if (item.ready)
				ctl_s1.valid <= item.valid;
			if (accept)
				ctl_s1.op <= item.data.op;
		end
	end

	slsdc_lane u_lane1 (
		.clk(clk),
		.en(accept),
		.re(item.data.bin1_real),
		.im(item.data.bin1_imag),
		.sleep_thr(sleep_threshold_q),
		.dance_thr(dance_threshold_q),
		.report(rep[0])
	);

	slsdc_lane u_lane2 (
		.clk(clk),
		.en(accept),
		.re(item.data.bin2_real),
		.im(item.data.bin2_imag),
		.sleep_thr(sleep_threshold_q),
		.dance_thr(dance_threshold_q),
		.report(rep[1])
	);

	slsdc_lane u_lane3 (
		.clk(clk),
		.en(accept),
		.re(item.data.bin3_real),
		.im(item.data.bin3_imag),
		.sleep_thr(sleep_threshold_q),
		.dance_thr(dance_threshold_q),
		.report(rep[2])
	);

	slsdc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.rep(rep),
		.dance_hold(dance_hold_q),
		.sleep_ticks(sleep_ticks_q),
		.advance(advance),
		.result(result)
	);

endmodule

@@ hdl/slsdc_lane.sv @@
module slsdc_lane (
	input  logic clk,
	input  logic en,
	input  logic signed [slsdc_pkg::PART_W-1:0] re,
	input  logic signed [slsdc_pkg::PART_W-1:0] im,
	input  logic [slsdc_pkg::POWER_W-1:0] sleep_thr,
	input  logic [slsdc_pkg::POWER_W-1:0] dance_thr,
	output slsdc_pkg::lane_report_t report
);

	logic [slsdc_pkg::PART_W-1:0] neg_re;
	logic [slsdc_pkg::PART_W-1:0] neg_im;
	logic [slsdc_pkg::MAG_W-1:0] mag_re;
	logic [slsdc_pkg::MAG_W-1:0] mag_im;
	logic [slsdc_pkg::POWER_W-1:0] power_s1;
	logic [slsdc_pkg::POWER_W-1:0] quarter_thr;
	logic [slsdc_pkg::POWER_W-slsdc_pkg::POWER_SHIFT-1:0] scaled;

	// saturating absolute value, the most negative code gives the largest positive
	always_comb begin
		neg_re = slsdc_pkg::PART_W'(16'd0 - re);
		neg_im = slsdc_pkg::PART_W'(16'd0 - im);
		if (!re[slsdc_pkg::PART_W-1])
			mag_re = re[slsdc_pkg::MAG_W-1:0];
		else if (neg_re[slsdc_pkg::PART_W-1])
			mag_re = '1;
		else
			mag_re = neg_re[slsdc_pkg::MAG_W-1:0];
		if (!im[slsdc_pkg::PART_W-1])
			mag_im = im[slsdc_pkg::MAG_W-1:0];
		else if (neg_im[slsdc_pkg::PART_W-1])
			mag_im = '1;
		else
			mag_im = neg_im[slsdc_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en)
			power_s1 <= slsdc_pkg::POWER_W'(mag_re) * slsdc_pkg::POWER_W'(mag_re) +
				slsdc_pkg::POWER_W'(mag_im) * slsdc_pkg::POWER_W'(mag_im);
	end

	always_comb begin
		quarter_thr = dance_thr >> slsdc_pkg::QUARTER_SHIFT;
		scaled = power_s1[slsdc_pkg::POWER_W-1:slsdc_pkg::POWER_SHIFT];
		report.over_sleep = power_s1 > sleep_thr;
		report.over_dance = power_s1 > dance_thr;
		report.over_quarter = power_s1 > quarter_thr;
		if (scaled > (slsdc_pkg::POWER_W-slsdc_pkg::POWER_SHIFT)'(slsdc_pkg::DUTY_CLAMP))
			report.duty = ~slsdc_pkg::DUTY_CLAMP;
		else
			report.duty = ~scaled[slsdc_pkg::DUTY_W-1:0];
	end

endmodule

@@ hdl/slsdc_ctrl.sv @@
module slsdc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  slsdc_pkg::stage_ctl_t ctl_s1,
	input  slsdc_pkg::lane_report_t rep [slsdc_pkg::LANES],
	input  logic [slsdc_pkg::TIMER_W-1:0] dance_hold,
	input  logic [slsdc_pkg::TIMER_W-1:0] sleep_ticks,
	output logic advance,
	slsdc_result_if.source result
);

	logic fire;
	logic v_s2;
	slsdc_pkg::result_word_t word_s2;
	slsdc_pkg::result_word_t word_n;

	logic [slsdc_pkg::TIMER_W-1:0] hold_timer_q;
	logic [slsdc_pkg::TIMER_W-1:0] hold_timer_n;
	logic [slsdc_pkg::TIMER_W-1:0] quiet_ticks_q;
	logic [slsdc_pkg::TIMER_W-1:0] quiet_ticks_n;
	logic loud_seen_q;
	logic loud_seen_n;
	logic sleeping_q;
	logic sleeping_n;

	logic any_loud;
	logic all_dance;
	logic any_quarter;

	assign advance = !v_s2 || result.ready;
	assign fire = ctl_s1.valid && advance;
	assign result.valid = v_s2;
	assign result.data = word_s2;

	always_comb begin
		any_loud = 1'b0;
		all_dance = 1'b1;
		any_quarter = 1'b0;
		for (int i = 0; i < slsdc_pkg::LANES; i++) begin
			any_loud = any_loud | rep[i].over_sleep;
			all_dance = all_dance & rep[i].over_dance;
			any_quarter = any_quarter | rep[i].over_quarter;
		end
	end

	always_comb begin
		hold_timer_n = hold_timer_q;
		quiet_ticks_n = quiet_ticks_q;
		loud_seen_n = loud_seen_q;
		sleeping_n = sleeping_q;
		word_n = '0;
		if (ctl_s1.op == slsdc_pkg::OP_FRAME) begin
			if (any_loud) begin
				loud_seen_n = 1'b1;
				sleeping_n = 1'b0;
			end
			if (!sleeping_n && (all_dance || hold_timer_q != '0)) begin
				if (any_quarter || hold_timer_q == '0)
					hold_timer_n = dance_hold;
				else
					hold_timer_n = hold_timer_q - 1'b1;
				word_n.dancing = 1'b1;
				word_n.duty_update = 1'b1;
				word_n.red_duty = rep[0].duty;
				word_n.green_duty = rep[1].duty;
				word_n.blue_duty = rep[2].duty;
			end
		end else begin
			if (!loud_seen_q) begin
				if (quiet_ticks_q != '1)
					quiet_ticks_n = quiet_ticks_q + 1'b1;
			end else begin
				quiet_ticks_n = '0;
				loud_seen_n = 1'b0;
			end
			if (quiet_ticks_n > sleep_ticks)
				sleeping_n = 1'b1;
		end
		word_n.asleep = sleeping_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_timer_q <= '0;
			quiet_ticks_q <= '0;
			loud_seen_q <= 1'b0;
			sleeping_q <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (fire) begin
				hold_timer_q <= hold_timer_n;
				quiet_ticks_q <= quiet_ticks_n;
				loud_seen_q <= loud_seen_n;
				sleeping_q <= sleeping_n;
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			word_s2 <= word_n;
	end

`ifndef SYNTHESIS
	a_dance_awake: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && word_s2.dancing |-> !word_s2.asleep && word_s2.duty_update)
		else $error("dancing result while asleep");

	a_tick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl_s1.op == slsdc_pkg::OP_TICK && loud_seen_q
		|=> quiet_ticks_q == '0 && !loud_seen_q)
		else $error("tick after loud frame did not clear quiet count");

	a_idle_frame_timer: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl_s1.op == slsdc_pkg::OP_FRAME && !word_n.dancing
		|=> $stable(hold_timer_q))
		else $error("hold timer moved on a frame outside dance mode");

	a_tick_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl_s1.op == slsdc_pkg::OP_TICK |=> !word_s2.duty_update)
		else $error("tick produced a duty update");
`endif

endmodule
